/* rtl/mbet_pkg.sv */
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, constants, CORDIC tables and control types for the
// power-8 Mandelbulb escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

   localparam int FRACTION_BITS = 20;
   localparam int CORDIC_STEPS  = 24;
   localparam int ANG_BITS      = 56;
   localparam int GAIN_BITS     = 60;

   localparam int COORD_W = 24;
   localparam int COUNT_W = 8;
   localparam int REQ_W   = 3 * COORD_W;
   localparam int VAL_W   = 34;
   localparam int MAG_W   = VAL_W - 1;
   localparam int ANG_W   = 64;
   localparam int COEF_W  = 64;
   localparam int HALF_W  = COEF_W / 2;
   localparam int PP_W    = MAG_W + HALF_W;
   localparam int ACC_W   = MAG_W + COEF_W;
   localparam int STEP_W  = $clog2(CORDIC_STEPS);

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(255);

   typedef logic [CORDIC_STEPS-1:0][ANG_W-1:0] atan_table_type;

   // unsigned quotient by restoring long division, for table building only
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // pi/4 with 62 fraction bits from the two Machin series
   function automatic logic [63:0] calc_pi4();
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] n;
      logic [63:0] a5;
      t = udiv64(64'h4000_0000_0000_0000, 64'd5);
      sum = t;
      n = 64'd1;
      while (t != 64'd0) begin
         t = udiv64(t, 64'd25);
         if (n[0]) sum = sum - udiv64(t, 2 * n + 64'd1);
         else sum = sum + udiv64(t, 2 * n + 64'd1);
         n = n + 64'd1;
      end
      a5 = sum;
      t = udiv64(64'h4000_0000_0000_0000, 64'd239);
      sum = t;
      n = 64'd1;
      while (t != 64'd0) begin
         t = udiv64(t, 64'd57121);
         if (n[0]) sum = sum - udiv64(t, 2 * n + 64'd1);
         else sum = sum + udiv64(t, 2 * n + 64'd1);
         n = n + 64'd1;
      end
      return (a5 << 2) - sum;
   endfunction

   localparam logic [63:0] PI4    = calc_pi4();
   localparam logic [63:0] PI4_X4 = PI4 << 2;

   localparam logic signed [ANG_W-1:0] PI_ANG     = $signed(PI4_X4 >> (62 - ANG_BITS));
   localparam logic signed [ANG_W-1:0] TWO_PI     = PI_ANG <<< 1;
   localparam logic signed [ANG_W-1:0] HALF_PI    = PI_ANG >>> 1;
   localparam logic signed [ANG_W-1:0] NEG_PI     = -PI_ANG;
   localparam logic signed [ANG_W-1:0] NEG_TWO_PI = -TWO_PI;
   localparam logic signed [ANG_W-1:0] NEG_HALF_PI = -HALF_PI;

   function automatic atan_table_type build_atan_table();
      atan_table_type tab;
      logic [63:0] sum;
      logic [63:0] q;
      int e;
      tab[0] = PI4 >> (62 - ANG_BITS);
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         sum = 64'd0;
         for (int n = 0; n < 64; n++) begin
            e = i * (2 * n + 1);
            if (e <= 62) begin
               q = udiv64(64'd1 << (62 - e), 64'(2 * n + 1));
               if ((n & 1) != 0) sum = sum - q;
               else sum = sum + q;
            end
         end
         tab[i] = sum >> (62 - ANG_BITS);
      end
      return tab;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

   // signed product, truncated toward zero, magnitude saturated
   function automatic logic signed [63:0] mulshift_const(logic signed [63:0] a,
                                                         logic signed [63:0] b,
                                                         int sh);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      logic [127:0] r;
      logic         neg;
      neg = a[63] ^ b[63];
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      r = p >> sh;
      if (r[127:63] != '0) r = {65'd0, 63'h7FFF_FFFF_FFFF_FFFF};
      return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
   endfunction

   function automatic logic signed [63:0] calc_inv_gain();
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] nx;
      logic signed [63:0] g;
      logic signed [63:0] v;
      logic signed [63:0] one;
      one = 64'sd1 <<< GAIN_BITS;
      x = one;
      y = 64'sd0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y < 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
         end
         x = nx;
      end
      g = x;
      v = $signed(udiv64(64'd6 << GAIN_BITS, 64'd10));
      for (int k = 0; k < 6; k++)
         v = mulshift_const(v, (one <<< 1) - mulshift_const(g, v, GAIN_BITS), GAIN_BITS);
      return v;
   endfunction

   localparam logic signed [COEF_W-1:0] INV_GAIN = calc_inv_gain();
   localparam logic signed [VAL_W-1:0]  TWO_FIX  = VAL_W'(64'd2 << FRACTION_BITS);

   // one entry per operation of an iteration, in issue order
   typedef enum logic [3:0] {
      PH_SQX, PH_SQY, PH_SQZ, PH_VEC1, PH_RHO, PH_VEC2,
      PH_S2, PH_R8, PH_MR, PH_ROT1, PH_MS, PH_ROT2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MUL_LOAD, ST_MUL_LO, ST_MUL_HI, ST_MUL_WRITE,
      ST_ESC_TEST, ST_CORD_LOAD, ST_CORD_REDUCE, ST_CORD_WRAP, ST_CORD_FOLD,
      ST_CORD_STEP, ST_CORD_DONE, ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic              start;
      logic              mul_load;
      logic              mul_lo;
      logic              mul_hi;
      logic              mul_write;
      logic              cord_load;
      logic              cord_reduce;
      logic              cord_wrap;
      logic              cord_fold;
      logic              cord_step;
      logic              cord_done;
      logic [STEP_W-1:0] step;
      phase_type         phase;
   } dp_cmd_type;

   typedef struct packed {
      logic at_limit;
      logic escaped;
      logic ang_big;
   } dp_status_type;

endpackage

/* rtl/mandelbulb_escape_time.sv */
// ----------------------------------------------------------------------------
// mandelbulb_escape_time
// Power-8 Mandelbulb escape-time evaluator for one 3D sample point a word.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per sample point, three signed coordinates with 20
//            fraction bits. A word is taken only while the block is idle.
//   rsp_*  : one word per point, the iteration count 0..max_iterations.
//   csr_*  : write max_iterations (low 8 bits kept) while idle.
// Iteration:
//   Each iteration runs 8 multiplies on the shared two-pass multiplier,
//   two vectoring runs and two rotation runs on the shared CORDIC unit
//   (a rotation adds one 2*pi angle reduction step per turn, at most 4
//   per rotation), the escape test and the limit check.
// Reset:
//   Synchronous, active high. Returns to idle, drops any pending result and
//   sets max_iterations to 255.
// Stall:
//   The count waits in an output register; the next point is accepted as
//   soon as the result is parked there, and evaluation of that point runs
//   while rsp_tready is low. A new result waits until the register drains.
// ----------------------------------------------------------------------------
module mandelbulb_escape_time import mbet_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,    // point_x, point_y, point_z
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [COUNT_W-1:0]  rsp_tdata,    // iteration_count
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data   // max_iterations
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [COUNT_W-1:0] count;
   logic               out_write;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_data_ff, rsp_data_in;

   // output register is free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   mbet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (status),
      .cmd        (cmd),
      .out_write  (out_write)
   );

   mbet_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .count       (count)
   );

   // hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_write) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = count;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/mbet_ctrl.sv */
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: walks one item through its iterations, issuing multiplier
// passes and CORDIC steps to the datapath.
// ----------------------------------------------------------------------------
module mbet_ctrl import mbet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          out_free,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          out_write
);

   ctrl_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;

   function automatic phase_type next_phase(phase_type p);
      phase_type r;
      unique case (p)
         PH_SQX:  r = PH_SQY;
         PH_SQY:  r = PH_SQZ;
         PH_SQZ:  r = PH_VEC1;
         PH_VEC1: r = PH_RHO;
         PH_RHO:  r = PH_VEC2;
         PH_VEC2: r = PH_S2;
         PH_S2:   r = PH_R8;
         PH_R8:   r = PH_MR;
         PH_MR:   r = PH_ROT1;
         PH_ROT1: r = PH_MS;
         PH_MS:   r = PH_ROT2;
         PH_ROT2: r = PH_SQX;
         default: r = PH_SQX;
      endcase
      return r;
   endfunction

   function automatic logic is_cordic(phase_type p);
      return (p == PH_VEC1) || (p == PH_VEC2) || (p == PH_ROT1) || (p == PH_ROT2);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SQX;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.phase  = phase_ff;
      cmd.step   = step_ff;
      req_tready = 1'b0;
      out_write  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.at_limit) begin
               state_in = ST_RESULT;
            end else begin
               phase_in = PH_SQX;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_MUL_WRITE;
         end
         ST_MUL_WRITE: begin
            cmd.mul_write = 1'b1;
            if (phase_ff == PH_SQZ) begin
               state_in = ST_ESC_TEST;
            end else begin
               phase_in = next_phase(phase_ff);
               state_in = is_cordic(next_phase(phase_ff)) ? ST_CORD_LOAD : ST_MUL_LOAD;
            end
         end
         ST_ESC_TEST: begin
            if (status.escaped) begin
               state_in = ST_RESULT;
            end else begin
               phase_in = PH_VEC1;
               state_in = ST_CORD_LOAD;
            end
         end
         ST_CORD_LOAD: begin
            cmd.cord_load = 1'b1;
            step_in       = '0;
            if (phase_ff == PH_ROT1 || phase_ff == PH_ROT2) state_in = ST_CORD_REDUCE;
            else state_in = ST_CORD_STEP;
         end
         ST_CORD_REDUCE: begin
            if (status.ang_big) cmd.cord_reduce = 1'b1;
            else state_in = ST_CORD_WRAP;
         end
         ST_CORD_WRAP: begin
            cmd.cord_wrap = 1'b1;
            state_in      = ST_CORD_FOLD;
         end
         ST_CORD_FOLD: begin
            cmd.cord_fold = 1'b1;
            state_in      = ST_CORD_STEP;
         end
         ST_CORD_STEP: begin
            cmd.cord_step = 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_CORD_DONE;
            else step_in = step_ff + STEP_W'(1);
         end
         ST_CORD_DONE: begin
            cmd.cord_done = 1'b1;
            if (phase_ff == PH_ROT2) begin
               state_in = ST_CHECK;
            end else begin
               phase_in = next_phase(phase_ff);
               state_in = is_cordic(next_phase(phase_ff)) ? ST_CORD_LOAD : ST_MUL_LOAD;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               out_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/mbet_dp.sv */
// ----------------------------------------------------------------------------
// mbet_dp
// Datapath: iterate registers, a shared two-pass multiplier and a shared
// one-step-per-cycle CORDIC unit for vectoring and rotation.
// ----------------------------------------------------------------------------
module mbet_dp import mbet_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   output dp_status_type       status,
   output logic [COUNT_W-1:0]  count
);

   logic [COUNT_W-1:0] max_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [VAL_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [VAL_W-1:0] s_ff, s_in, t_ff, t_in, ct_ff, ct_in, st_ff, st_in;
   logic signed [ANG_W-1:0] phi_ff, phi_in, theta_ff, theta_in;
   logic signed [VAL_W-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [ANG_W-1:0] la_ff, la_in;
   logic rot_ff, rot_in, zero_ff, zero_in, neg_ff, neg_in;
   logic [MAG_W-1:0]  ma_ff, ma_in;
   logic [COEF_W-1:0] mb_ff, mb_in;
   logic mneg_ff, mneg_in, mbig_ff, mbig_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic signed [VAL_W-1:0]  a_sel;
   logic signed [COEF_W-1:0] b_sel;
   logic                     big_sel;
   logic [VAL_W-1:0]         a_abs;
   logic [COEF_W-1:0]        b_abs;
   logic [HALF_W-1:0]        b_half;
   logic [PP_W-1:0]          pp;
   logic [ACC_W-1:0]         acc_sh;
   logic [VAL_W-1:0]         prod_mag;
   logic signed [VAL_W-1:0]  prod;
   logic signed [VAL_W-1:0]  vx, vy, lx_sh, ly_sh, fix_x, fix_y;
   logic signed [ANG_W-1:0]  rom, rot_ang;
   logic                     ccw;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) max_ff <= MAX_ITER_RESET;
      else if (csr_wr_en) max_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
      x_ff <= x_in;    y_ff <= y_in;    z_ff <= z_in;
      s_ff <= s_in;    t_ff <= t_in;    ct_ff <= ct_in;  st_ff <= st_in;
      phi_ff <= phi_in;  theta_ff <= theta_in;
      lx_ff <= lx_in;  ly_ff <= ly_in;  la_ff <= la_in;
      rot_ff <= rot_in;  zero_ff <= zero_in;  neg_ff <= neg_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  mneg_ff <= mneg_in;  mbig_ff <= mbig_in;
      acc_ff <= acc_in;
   end

   // multiplier operand selection
   always_comb begin
      a_sel   = t_ff;
      b_sel   = COEF_W'(t_ff);
      big_sel = 1'b0;
      case (cmd.phase)
         PH_SQX: begin
            a_sel = x_ff;  b_sel = COEF_W'(x_ff);
         end
         PH_SQY: begin
            a_sel = y_ff;  b_sel = COEF_W'(y_ff);
         end
         PH_SQZ: begin
            a_sel = z_ff;  b_sel = COEF_W'(z_ff);
         end
         PH_S2: begin
            a_sel = s_ff;  b_sel = COEF_W'(s_ff);
         end
         PH_MS: begin
            a_sel = st_ff;  b_sel = INV_GAIN;  big_sel = 1'b1;
         end
         PH_RHO, PH_MR: begin
            b_sel = INV_GAIN;  big_sel = 1'b1;
         end
         default: ;
      endcase
   end

   assign a_abs    = a_sel[VAL_W-1] ? -a_sel : a_sel;
   assign b_abs    = b_sel[COEF_W-1] ? -b_sel : b_sel;
   assign b_half   = cmd.mul_hi ? mb_ff[COEF_W-1:HALF_W] : mb_ff[HALF_W-1:0];
   assign pp       = ma_ff * b_half;
   assign acc_sh   = mbig_ff ? (acc_ff >> GAIN_BITS) : (acc_ff >> FRACTION_BITS);
   assign prod_mag = acc_sh[VAL_W-1:0];
   assign prod     = mneg_ff ? -$signed(prod_mag) : $signed(prod_mag);

   // CORDIC operands
   assign vx      = (cmd.phase == PH_VEC2) ? z_ff : x_ff;
   assign vy      = (cmd.phase == PH_VEC2) ? t_ff : y_ff;
   assign rot_ang = (cmd.phase == PH_ROT1) ? (theta_ff <<< 3) : (phi_ff <<< 3);
   assign lx_sh   = lx_ff >>> cmd.step;
   assign ly_sh   = ly_ff >>> cmd.step;
   assign rom     = $signed(ATAN_TABLE[cmd.step]);
   assign ccw     = rot_ff ? ~la_ff[ANG_W-1] : ly_ff[VAL_W-1];
   assign fix_x   = neg_ff ? -lx_ff : lx_ff;
   assign fix_y   = neg_ff ? -ly_ff : ly_ff;

   always_comb begin
      count_in = count_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      x_in = x_ff;    y_in = y_ff;    z_in = z_ff;
      s_in = s_ff;    t_in = t_ff;    ct_in = ct_ff;  st_in = st_ff;
      phi_in = phi_ff;  theta_in = theta_ff;
      lx_in = lx_ff;  ly_in = ly_ff;  la_in = la_ff;
      rot_in = rot_ff;  zero_in = zero_ff;  neg_in = neg_ff;
      ma_in = ma_ff;  mb_in = mb_ff;  mneg_in = mneg_ff;  mbig_in = mbig_ff;
      acc_in = acc_ff;

      if (cmd.start) begin
         cx_in = req_tdata[COORD_W-1:0];
         cy_in = req_tdata[2*COORD_W-1:COORD_W];
         cz_in = req_tdata[3*COORD_W-1:2*COORD_W];
         x_in = '0;  y_in = '0;  z_in = '0;
         count_in = '0;
      end else if (cmd.mul_load) begin
         ma_in   = a_abs[MAG_W-1:0];
         mb_in   = b_abs;
         mneg_in = a_sel[VAL_W-1] ^ b_sel[COEF_W-1];
         mbig_in = big_sel;
      end else if (cmd.mul_lo) begin
         acc_in = ACC_W'(pp);
      end else if (cmd.mul_hi) begin
         acc_in = acc_ff + {pp, HALF_W'(0)};
      end else if (cmd.mul_write) begin
         case (cmd.phase)
            PH_SQX:         s_in = prod;
            PH_SQY, PH_SQZ: s_in = s_ff + prod;
            default:        t_in = prod;
         endcase
      end else if (cmd.cord_load) begin
         neg_in = 1'b0;
         if (cmd.phase == PH_ROT1 || cmd.phase == PH_ROT2) begin
            rot_in  = 1'b1;
            zero_in = 1'b0;
            lx_in   = t_ff;
            ly_in   = '0;
            la_in   = rot_ang;
         end else begin
            rot_in  = 1'b0;
            zero_in = (vx == '0) && (vy == '0);
            if (vx[VAL_W-1]) begin
               // turn the vector by pi into the right half plane
               la_in = vy[VAL_W-1] ? NEG_PI : PI_ANG;
               lx_in = -vx;
               ly_in = -vy;
            end else begin
               la_in = '0;
               lx_in = vx;
               ly_in = vy;
            end
         end
      end else if (cmd.cord_reduce) begin
         if (la_ff >= TWO_PI) la_in = la_ff - TWO_PI;
         else la_in = la_ff + TWO_PI;
      end else if (cmd.cord_wrap) begin
         if (la_ff > PI_ANG) la_in = la_ff - TWO_PI;
         else if (la_ff <= NEG_PI) la_in = la_ff + TWO_PI;
      end else if (cmd.cord_fold) begin
         if (la_ff > HALF_PI) begin
            la_in  = la_ff - PI_ANG;
            neg_in = 1'b1;
         end else if (la_ff < NEG_HALF_PI) begin
            la_in  = la_ff + PI_ANG;
            neg_in = 1'b1;
         end
      end else if (cmd.cord_step) begin
         if (ccw) begin
            lx_in = lx_ff - ly_sh;
            ly_in = ly_ff + lx_sh;
            la_in = la_ff - rom;
         end else begin
            lx_in = lx_ff + ly_sh;
            ly_in = ly_ff - lx_sh;
            la_in = la_ff + rom;
         end
      end else if (cmd.cord_done) begin
         case (cmd.phase)
            PH_VEC1: begin
               phi_in = zero_ff ? '0 : la_ff;
               t_in   = lx_ff;
            end
            PH_VEC2: theta_in = zero_ff ? '0 : la_ff;
            PH_ROT1: begin
               ct_in = fix_x;
               st_in = fix_y;
            end
            default: begin
               x_in     = fix_x + VAL_W'(cx_ff);
               y_in     = fix_y + VAL_W'(cy_ff);
               z_in     = ct_ff + VAL_W'(cz_ff);
               count_in = count_ff + COUNT_W'(1);
            end
         endcase
      end
   end

   assign status.at_limit = (count_ff >= max_ff);
   assign status.escaped  = (s_ff >= TWO_FIX);
   assign status.ang_big  = (la_ff >= TWO_PI) || (la_ff <= NEG_TWO_PI);
   assign count           = count_ff;

endmodule
